/* src/irwr_pkg.sv */
// Shared constants and types for the rotation resampler.
`timescale 1ns / 1ps

package irwr_pkg;

    // Store and geometry limits.
    localparam int MAX_SRC_W   = 256;
    localparam int MAX_SRC_H   = 256;
    localparam int MAX_OUT_DIM = 512;
    localparam int FRAC_BITS   = 14;

    // Coordinate and bank address widths; four banks by column and row parity.
    localparam int XW         = $clog2(MAX_SRC_W);
    localparam int YW         = $clog2(MAX_SRC_H);
    localparam int BANK_AW    = (XW - 1) + (YW - 1);
    localparam int BANK_DEPTH = (MAX_SRC_W * MAX_SRC_H) / 4;

    // Distance, quotient and root widths of the ratio lanes.
    localparam int DIST_W     = 32;
    localparam int QUO_W      = 25;
    localparam int ROOT_W     = 13;
    localparam int DIV_STEPS  = QUO_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int RATIO_LAT  = DIV_STEPS + SQRT_STEPS;

    // Ratio of the nearest neighbor to itself, 1.0 in Q1.12.
    localparam logic [ROOT_W-1:0] RATIO_ONE = ROOT_W'(4096);

    typedef logic [23:0] rgb_t;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_COS    = 3'd0,
        CFG_SIN    = 3'd1,
        CFG_SRC_W  = 3'd2,
        CFG_SRC_H  = 3'd3,
        CFG_OUT_W  = 3'd4,
        CFG_OUT_H  = 3'd5,
        CFG_RANK   = 3'd6
    } cfg_idx_t;

endpackage

/* src/irwr_ratio.sv */
// Pipelined ratio lane: sqrt(floor(d_near * 2^24 / d_far)) in Q1.12.
`timescale 1ns / 1ps

module irwr_ratio
    import irwr_pkg::*;
(
    input  logic              clk,
    input  logic [DIST_W-1:0] d_near,
    input  logic [DIST_W-1:0] d_far,
    output logic [ROOT_W-1:0] ratio
);

    logic [DIST_W-1:0] rem_reg  [DIV_STEPS];
    logic [DIST_W-1:0] rem_next [DIV_STEPS];
    logic [QUO_W-1:0]  quo_reg  [DIV_STEPS];
    logic [QUO_W-1:0]  quo_next [DIV_STEPS];
    logic [DIST_W-1:0] dvs_reg  [DIV_STEPS];
    logic [DIST_W-1:0] dvs_next [DIV_STEPS];

    logic [QUO_W-1:0]  sv_reg   [SQRT_STEPS];
    logic [QUO_W-1:0]  sv_next  [SQRT_STEPS];
    logic [QUO_W:0]    sr_reg   [SQRT_STEPS];
    logic [QUO_W:0]    sr_next  [SQRT_STEPS];

    // Restoring division, one quotient bit per stage, most significant first.
    always_comb
    begin
        logic [DIST_W-1:0] trial;
        logic [DIST_W-1:0] dvs;
        logic [QUO_W-1:0]  qin;
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            if (s == 0)
            begin
                trial = d_near;
                dvs   = d_far;
                qin   = '0;
            end
            else
            begin
                trial = {rem_reg[(s == 0) ? 0 : s - 1][DIST_W-2:0], 1'b0};
                dvs   = dvs_reg[(s == 0) ? 0 : s - 1];
                qin   = quo_reg[(s == 0) ? 0 : s - 1];
            end
            dvs_next[s] = dvs;
            if (trial >= dvs)
            begin
                rem_next[s] = trial - dvs;
                quo_next[s] = {qin[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[s] = trial;
                quo_next[s] = {qin[QUO_W-2:0], 1'b0};
            end
        end
    end

    // Digit-by-digit square root, one root bit per stage.
    always_comb
    begin
        logic [QUO_W-1:0] vin;
        logic [QUO_W:0]   rin;
        logic [QUO_W:0]   bitv;
        logic [QUO_W:0]   trial;
        for (int s = 0; s < SQRT_STEPS; s++)
        begin
            if (s == 0)
            begin
                vin = quo_reg[DIV_STEPS-1];
                rin = '0;
            end
            else
            begin
                vin = sv_reg[(s == 0) ? 0 : s - 1];
                rin = sr_reg[(s == 0) ? 0 : s - 1];
            end
            bitv  = (QUO_W + 1)'(1) << (2 * (SQRT_STEPS - 1 - s));
            trial = rin + bitv;
            if ({1'b0, vin} >= trial)
            begin
                sv_next[s] = vin - trial[QUO_W-1:0];
                sr_next[s] = (rin >> 1) + bitv;
            end
            else
            begin
                sv_next[s] = vin;
                sr_next[s] = rin >> 1;
            end
        end
    end

    // Stage registers carry payload only; validity travels beside the lane.
    always_ff @(posedge clk)
    begin
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            rem_reg[s] <= rem_next[s];
            quo_reg[s] <= quo_next[s];
            dvs_reg[s] <= dvs_next[s];
        end
        for (int s = 0; s < SQRT_STEPS; s++)
        begin
            sv_reg[s] <= sv_next[s];
            sr_reg[s] <= sr_next[s];
        end
    end

    assign ratio = sr_reg[SQRT_STEPS-1][ROOT_W-1:0];

endmodule

/* src/image_rotate_weighted_resampler_core.sv */
// Top level of the rotation resampler with inverse-distance weighting.
`timescale 1ns / 1ps

// Usage:
//   Input beats are accepted when start is high and busy is low. busy stays
//   low: a new beat may be offered in every cycle. A load beat (req_type 0)
//   writes one RGB pixel into the source store and returns nothing. A query
//   beat (req_type 1) returns one result beat: done marks it, and the beat is
//   taken at the edge that ends the cycle in which done is high.
//   Throughput is one beat per cycle. The source store is split into four
//   banks by column and row parity, so the four neighbors are read in the same
//   cycle; the divide and square root run as 38 pipelined steps per ratio lane.
//   Loads write the store at the same stage where queries read it, so every
//   query sees exactly the loads that were accepted before it.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_data). The user
//   writes it only while no query is in flight; the block does not enforce this.
//   Reset clears the pipeline valid bits and sets the configuration registers to
//   their defaults. The source store is not cleared and must be loaded before use.
//   The receiver cannot stall: each result beat is held for one cycle only.
module image_rotate_weighted_resampler_core
    import irwr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        req_type,
    input  logic [8:0]  pos_x,
    input  logic [8:0]  pos_y,
    input  logic [7:0]  in_red,
    input  logic [7:0]  in_green,
    input  logic [7:0]  in_blue,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output logic        done,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue,
    output logic        outside
);

    localparam int SIDE_LEN = RATIO_LAT + 5;

    typedef struct packed {
        rgb_t [3:0] col;
        logic [3:0] smask;
        logic       none;
        logic       zero;
    } side_t;

    // Truncation toward zero of a fixed-point coordinate.
    function automatic logic signed [31:0] trunc_frac(input logic signed [31:0] v);
        logic signed [31:0] neg;
        neg = -v;
        if (v < 0)
            return -(neg >>> FRAC_BITS);
        else
            return v >>> FRAC_BITS;
    endfunction

    function automatic logic in_range(input logic signed [31:0] c, input logic [8:0] lim);
        return (c >= 0) && (c < $signed({23'b0, lim}));
    endfunction

    // Configuration registers.
    logic signed [15:0] cos_reg;
    logic signed [15:0] sin_reg;
    logic [8:0]         src_w_reg;
    logic [8:0]         src_h_reg;
    logic [9:0]         out_w_reg;
    logic [9:0]         out_h_reg;
    logic [63:0]        rank_reg;

    logic [8:0] sw_used;
    logic [8:0] sh_used;
    logic [9:0] ow_used;
    logic [9:0] oh_used;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg   <= 16'sd16384;
            sin_reg   <= 16'sd0;
            src_w_reg <= 9'd256;
            src_h_reg <= 9'd256;
            out_w_reg <= 10'd256;
            out_h_reg <= 10'd256;
            rank_reg  <= 64'h1000_1000_1000_1000;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_COS:   cos_reg   <= $signed(cfg_data[15:0]);
                CFG_SIN:   sin_reg   <= $signed(cfg_data[15:0]);
                CFG_SRC_W: src_w_reg <= cfg_data[8:0];
                CFG_SRC_H: src_h_reg <= cfg_data[8:0];
                CFG_OUT_W: out_w_reg <= cfg_data[9:0];
                CFG_OUT_H: out_h_reg <= cfg_data[9:0];
                CFG_RANK:  rank_reg  <= cfg_data;
                default:   ;
            endcase
        end
    end

    assign sw_used = (src_w_reg > 9'(MAX_SRC_W)) ? 9'(MAX_SRC_W) : src_w_reg;
    assign sh_used = (src_h_reg > 9'(MAX_SRC_H)) ? 9'(MAX_SRC_H) : src_h_reg;
    assign ow_used = (out_w_reg > 10'(MAX_OUT_DIM)) ? 10'(MAX_OUT_DIM) : out_w_reg;
    assign oh_used = (out_h_reg > 10'(MAX_OUT_DIM)) ? 10'(MAX_OUT_DIM) : out_h_reg;

    assign busy = 1'b0;

    // Stage 0: capture the input beat.
    logic       s0_v_reg;
    logic       s0_q_reg;
    logic [8:0] s0_px_reg;
    logic [8:0] s0_py_reg;
    rgb_t       s0_rgb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_v_reg <= 1'b0;
        else
            s0_v_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        s0_q_reg   <= req_type;
        s0_px_reg  <= pos_x;
        s0_py_reg  <= pos_y;
        s0_rgb_reg <= {in_red, in_green, in_blue};
    end

    // Stage 1: offsets from the output center and the four rotation products.
    logic signed [11:0] dx2;
    logic signed [11:0] dy2;
    logic signed [27:0] s1_xc_reg, s1_ys_reg, s1_xs_reg, s1_yc_reg;
    logic               s1_v_reg;
    logic               s1_q_reg;
    logic [8:0]         s1_px_reg;
    logic [8:0]         s1_py_reg;
    rgb_t               s1_rgb_reg;

    assign dx2 = $signed({2'b00, s0_px_reg, 1'b0}) - $signed({2'b00, ow_used}) + 12'sd1;
    assign dy2 = $signed({2'b00, s0_py_reg, 1'b0}) - $signed({2'b00, oh_used}) + 12'sd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else
            s1_v_reg <= s0_v_reg;
    end

    always_ff @(posedge clk)
    begin
        s1_q_reg   <= s0_q_reg;
        s1_px_reg  <= s0_px_reg;
        s1_py_reg  <= s0_py_reg;
        s1_rgb_reg <= s0_rgb_reg;
        s1_xc_reg  <= dx2 * cos_reg;
        s1_ys_reg  <= dy2 * sin_reg;
        s1_xs_reg  <= dx2 * sin_reg;
        s1_yc_reg  <= dy2 * cos_reg;
    end

    // Stage 2: source point, halved with floor to FRAC_BITS fraction bits.
    logic signed [31:0] base_x, base_y, sum_x, sum_y;
    logic signed [31:0] s2_sx_reg, s2_sy_reg;
    logic               s2_v_reg;
    logic               s2_q_reg;
    logic [8:0]         s2_px_reg;
    logic [8:0]         s2_py_reg;
    rgb_t               s2_rgb_reg;

    assign base_x = $signed((32'(sw_used) - 32'd1) << FRAC_BITS);
    assign base_y = $signed((32'(sh_used) - 32'd1) << FRAC_BITS);
    assign sum_x  = base_x + 32'(s1_xc_reg) + 32'(s1_ys_reg);
    assign sum_y  = base_y - 32'(s1_xs_reg) + 32'(s1_yc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_v_reg <= 1'b0;
        else
            s2_v_reg <= s1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_q_reg   <= s1_q_reg;
        s2_px_reg  <= s1_px_reg;
        s2_py_reg  <= s1_py_reg;
        s2_rgb_reg <= s1_rgb_reg;
        s2_sx_reg  <= sum_x >>> 1;
        s2_sy_reg  <= sum_y >>> 1;
    end

    // Stage 3: neighbors, range checks, fractional offsets and bank access.
    logic signed [31:0] tx, tx1, ty, ty1;
    logic [3:0]         nb_in;
    logic [BANK_AW-1:0] bank_raddr [4];
    logic [BANK_AW-1:0] bank_waddr;
    logic [3:0]         bank_we;
    rgb_t               bank_rd    [4];

    assign tx  = trunc_frac(s2_sx_reg);
    assign tx1 = tx + 32'sd1;
    assign ty  = trunc_frac(s2_sy_reg);
    assign ty1 = trunc_frac(s2_sy_reg + (32'sd1 <<< FRAC_BITS));

    assign nb_in[0] = in_range(tx, sw_used) && in_range(ty, sh_used);
    assign nb_in[1] = in_range(tx, sw_used) && in_range(ty1, sh_used);
    assign nb_in[2] = in_range(tx1, sw_used) && in_range(ty1, sh_used);
    assign nb_in[3] = in_range(tx1, sw_used) && in_range(ty, sh_used);

    // Each bank serves the one column and row of its parity.
    always_comb
    begin
        logic [31:0] col;
        logic [31:0] row;
        for (int b = 0; b < 4; b++)
        begin
            col = (tx[0] == b[0]) ? tx : tx1;
            row = (ty[0] == b[1]) ? ty : ty1;
            bank_raddr[b] = {row[YW-1:1], col[XW-1:1]};
        end
    end

    // A load writes its pixel at this same stage.
    always_comb
    begin
        logic wr;
        wr = s2_v_reg && !s2_q_reg && (s2_px_reg < 9'(MAX_SRC_W))
            && (s2_py_reg < 9'(MAX_SRC_H));
        bank_waddr = {s2_py_reg[YW-1:1], s2_px_reg[XW-1:1]};
        for (int b = 0; b < 4; b++)
            bank_we[b] = wr && (s2_px_reg[0] == b[0]) && (s2_py_reg[0] == b[1]);
    end

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        rgb_t mem [BANK_DEPTH];
        rgb_t rd_reg;

        always_ff @(posedge clk)
        begin
            if (bank_we[b])
                mem[bank_waddr] <= s2_rgb_reg;
            rd_reg <= mem[bank_raddr[b]];
        end

        assign bank_rd[b] = rd_reg;
    end

    logic               s3_v_reg;
    logic signed [16:0] s3_fxa_reg, s3_fxb_reg, s3_fya_reg, s3_fyb_reg;
    logic [3:0]         s3_in_reg;
    logic               s3_xp_reg, s3_yp_reg, s3_y1p_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_v_reg <= 1'b0;
        else
            s3_v_reg <= s2_v_reg && s2_q_reg;
    end

    always_ff @(posedge clk)
    begin
        s3_fxa_reg <= 17'(s2_sx_reg - (tx <<< FRAC_BITS));
        s3_fxb_reg <= 17'(s2_sx_reg - (tx1 <<< FRAC_BITS));
        s3_fya_reg <= 17'(s2_sy_reg - (ty <<< FRAC_BITS));
        s3_fyb_reg <= 17'(s2_sy_reg - (ty1 <<< FRAC_BITS));
        s3_in_reg  <= nb_in;
        s3_xp_reg  <= tx[0];
        s3_yp_reg  <= ty[0];
        s3_y1p_reg <= ty1[0];
    end

    // Stage 4: squared offsets and neighbor colors from the banks.
    logic              s4_v_reg;
    logic [DIST_W-1:0] s4_sxa_reg, s4_sxb_reg, s4_sya_reg, s4_syb_reg;
    logic [3:0]        s4_in_reg;
    rgb_t              s4_col_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_v_reg <= 1'b0;
        else
            s4_v_reg <= s3_v_reg;
    end

    always_ff @(posedge clk)
    begin
        s4_sxa_reg    <= 32'(s3_fxa_reg) * 32'(s3_fxa_reg);
        s4_sxb_reg    <= 32'(s3_fxb_reg) * 32'(s3_fxb_reg);
        s4_sya_reg    <= 32'(s3_fya_reg) * 32'(s3_fya_reg);
        s4_syb_reg    <= 32'(s3_fyb_reg) * 32'(s3_fyb_reg);
        s4_in_reg     <= s3_in_reg;
        s4_col_reg[0] <= bank_rd[{s3_yp_reg, s3_xp_reg}];
        s4_col_reg[1] <= bank_rd[{s3_y1p_reg, s3_xp_reg}];
        s4_col_reg[2] <= bank_rd[{s3_y1p_reg, ~s3_xp_reg}];
        s4_col_reg[3] <= bank_rd[{s3_yp_reg, ~s3_xp_reg}];
    end

    // Stage 5: squared distances.
    logic              s5_v_reg;
    logic [DIST_W-1:0] s5_d_reg   [4];
    logic [3:0]        s5_in_reg;
    rgb_t              s5_col_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_v_reg <= 1'b0;
        else
            s5_v_reg <= s4_v_reg;
    end

    always_ff @(posedge clk)
    begin
        s5_d_reg[0] <= s4_sxa_reg + s4_sya_reg;
        s5_d_reg[1] <= s4_sxa_reg + s4_syb_reg;
        s5_d_reg[2] <= s4_sxb_reg + s4_syb_reg;
        s5_d_reg[3] <= s4_sxb_reg + s4_sya_reg;
        s5_in_reg   <= s4_in_reg;
        s5_col_reg  <= s4_col_reg;
    end

    // Stage 6: stable sort of the kept neighbors by distance.
    logic [DIST_W-1:0] sd_next [4];
    logic [DIST_W-1:0] s6_d_reg [4];
    side_t             side_next;

    always_comb
    begin
        logic [2:0] rank [4];
        logic [2:0] cnt;
        cnt = 3'd0;
        for (int i = 0; i < 4; i++)
        begin
            rank[i] = 3'd0;
            for (int j = 0; j < 4; j++)
            begin
                if (j != i && s5_in_reg[j]
                    && (s5_d_reg[j] < s5_d_reg[i] || (s5_d_reg[j] == s5_d_reg[i] && j < i)))
                    rank[i] = rank[i] + 3'd1;
            end
            if (s5_in_reg[i])
                cnt = cnt + 3'd1;
        end
        side_next.zero = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            sd_next[k]          = '0;
            side_next.col[k]    = '0;
            side_next.smask[k]  = (3'(k) < cnt);
            for (int i = 0; i < 4; i++)
            begin
                if (s5_in_reg[i] && rank[i] == 3'(k))
                begin
                    sd_next[k]       = s5_d_reg[i];
                    side_next.col[k] = s5_col_reg[i];
                end
            end
            if (s5_in_reg[k] && s5_d_reg[k] == '0)
                side_next.zero = 1'b1;
        end
        side_next.none = (s5_in_reg == 4'b0000);
    end

    always_ff @(posedge clk)
    begin
        s6_d_reg <= sd_next;
    end

    // Side line: colors and flags travel alongside the ratio lanes.
    side_t   side_reg   [SIDE_LEN];
    logic [SIDE_LEN-1:0] side_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side_v_reg <= '0;
        else
            side_v_reg <= {side_v_reg[SIDE_LEN-2:0], s5_v_reg};
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_next;
        for (int i = 1; i < SIDE_LEN; i++)
            side_reg[i] <= side_reg[i-1];
    end

    // Ratio lanes for ranks one to three; rank zero is exactly one.
    logic [ROOT_W-1:0] ratio [4];

    assign ratio[0] = RATIO_ONE;

    for (genvar k = 1; k < 4; k++)
    begin : g_ratio
        irwr_ratio u_ratio (
            .clk    (clk),
            .d_near (s6_d_reg[0]),
            .d_far  (s6_d_reg[k]),
            .ratio  (ratio[k])
        );
    end

    // Weights: ratio times rank factor, zero for ranks not present.
    logic signed [29:0] w_reg [4];

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            if (side_reg[RATIO_LAT].smask[k])
                w_reg[k] <= $signed({1'b0, ratio[k]}) * $signed(rank_reg[16*k +: 16]);
            else
                w_reg[k] <= '0;
        end
    end

    // Terms: weight times each color channel.
    logic signed [38:0] term_reg [4][3];

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            for (int c = 0; c < 3; c++)
                term_reg[k][c] <= w_reg[k]
                    * $signed({1'b0, side_reg[RATIO_LAT+1].col[k][8*(2-c) +: 8]});
        end
    end

    // Adder tree over the four ranks.
    logic signed [39:0] pa_reg [3];
    logic signed [39:0] pb_reg [3];
    logic signed [40:0] sum_reg [3];

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            pa_reg[c]  <= 40'(term_reg[0][c]) + 40'(term_reg[1][c]);
            pb_reg[c]  <= 40'(term_reg[2][c]) + 40'(term_reg[3][c]);
            sum_reg[c] <= 41'(pa_reg[c]) + 41'(pb_reg[c]);
        end
    end

    // Output stage: saturation and the outside and exact-hit cases.
    logic [7:0] chan [3];
    side_t      fin;

    assign fin = side_reg[SIDE_LEN-1];

    always_comb
    begin
        logic [16:0] hi;
        for (int c = 0; c < 3; c++)
        begin
            hi = sum_reg[c][40:24];
            if (sum_reg[c] < 0)
                chan[c] = 8'd0;
            else if (hi > 17'd255)
                chan[c] = 8'd255;
            else
                chan[c] = hi[7:0];
            if (fin.none)
                chan[c] = 8'd0;
            else if (fin.zero)
                chan[c] = fin.col[0][8*(2-c) +: 8];
        end
    end

    logic       done_reg;
    logic [7:0] red_reg, green_reg, blue_reg;
    logic       outside_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= side_v_reg[SIDE_LEN-1];
    end

    always_ff @(posedge clk)
    begin
        red_reg     <= chan[0];
        green_reg   <= chan[1];
        blue_reg    <= chan[2];
        outside_reg <= fin.none;
    end

    assign done      = done_reg;
    assign out_red   = red_reg;
    assign out_green = green_reg;
    assign out_blue  = blue_reg;
    assign outside   = outside_reg;

endmodule
